FILE: sv/b64_pkg.sv
package b64_pkg;

  localparam int unsigned ResPerItem = 4;
  localparam logic [7:0]  PadChar    = 8'h3d;  // '='

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } res_t;

  // Symbol alphabet: a-z (0..25), A-Z (26..51), 0-9 (52..61), '+', '/'.
  function automatic logic [7:0] enc_sym(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'(8'h61 + {2'b00, v});
    end else if (v < 6'd52) begin
      c = 8'(8'h41 + {2'b00, v} - 8'd26);
    end else if (v < 6'd62) begin
      c = 8'(8'h30 + {2'b00, v} - 8'd52);
    end else if (v == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

  // Returns {ok, value}; ok is low for '=' and for any character outside the alphabet.
  function automatic logic [6:0] dec_sym(input logic [7:0] c);
    logic [6:0] r;
    if (c inside {[8'h61:8'h7a]}) begin
      r = {1'b1, 6'(c - 8'h61)};
    end else if (c inside {[8'h41:8'h5a]}) begin
      r = {1'b1, 6'(c - 8'h41 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2b) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2f) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

FILE: sv/base64_codec.sv
// Streaming base64 codec (alphabet order a-z, A-Z, 0-9, '+', '/'). With decode_mode
// low, bytes are packed three at a time into four characters, and a short group at
// end of stream is padded with '='. With decode_mode high, characters are mapped back
// to 6-bit symbols and every four symbols give three bytes; the first '=' or
// non-alphabet character stops decoding until end of stream, and a short final group
// gives one byte fewer than its symbol count. Every request marked end_of_stream yields
// a final result with out_last_o set, carrying no byte (out_valid_o low) if nothing was
// pending. A request is taken and all of its results are written at once into an
// eight-entry result queue; the queue drains one result per cycle while res_ready_i
// is high, so the output port sets the rate: one request per cycle while decoding
// (three bytes per four characters), and three bytes per four characters sent
// while encoding. The input is ready whenever the queue holds at most four results,
// so requests keep flowing while earlier results wait on the output. Writing the mode
// register clears any group in progress and is meant for an idle block.
module base64_codec
  import b64_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration: decode_mode register.
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // Input requests.
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       has_byte_i,
  input  logic       end_of_stream_i,
  // Results.
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic       out_last_o
);

  localparam int unsigned QDepth = 2 * ResPerItem;

  // Codec state.
  logic        mode_q;
  logic [17:0] bits_q, bits_d;
  logic [1:0]  cnt_g_q, cnt_g_d;
  logic        stop_q, stop_d;

  // Result queue: entry 0 is the head; entries shift down as results are taken.
  res_t        q_q [QDepth];
  res_t        q_d [QDepth];
  logic [3:0]  qcnt_q, qcnt_d;

  res_t        r [ResPerItem];
  logic [2:0]  n;
  logic        acc, pop;
  logic [23:0] w;
  logic [6:0]  dv;
  logic [3:0]  base;

  assign in_ready_o  = (qcnt_q <= 4'(ResPerItem));
  assign acc         = in_valid_i && in_ready_o;
  assign res_valid_o = (qcnt_q != 4'd0);
  assign pop         = res_valid_o && res_ready_i;
  assign out_byte_o  = q_q[0].data;
  assign out_valid_o = q_q[0].valid;
  assign out_last_o  = q_q[0].last;

  assign dv = dec_sym(data_byte_i);

  // Per-request datapath: next group state and up to four results.
  always_comb begin
    bits_d  = bits_q;
    cnt_g_d = cnt_g_q;
    stop_d  = stop_q;
    n       = 3'd0;
    w       = 24'd0;
    for (int i = 0; i < ResPerItem; i++) begin
      r[i] = '{data: 8'h00, valid: 1'b0, last: 1'b0};
    end

    if (!mode_q) begin
      if (has_byte_i && cnt_g_q >= 2'd2) begin
        // Third byte completes a group: four characters.
        w    = {bits_q[15:0], data_byte_i};
        r[0] = '{data: enc_sym(w[23:18]), valid: 1'b1, last: 1'b0};
        r[1] = '{data: enc_sym(w[17:12]), valid: 1'b1, last: 1'b0};
        r[2] = '{data: enc_sym(w[11:6]),  valid: 1'b1, last: 1'b0};
        r[3] = '{data: enc_sym(w[5:0]),   valid: 1'b1, last: 1'b0};
        n       = 3'd4;
        bits_d  = 18'd0;
        cnt_g_d = 2'd0;
      end else begin
        if (has_byte_i) begin
          bits_d  = {bits_q[9:0], data_byte_i};
          cnt_g_d = 2'(cnt_g_q + 2'd1);
        end
        if (end_of_stream_i && cnt_g_d == 2'd1) begin
          w    = {bits_d[7:0], 16'h0000};
          r[0] = '{data: enc_sym(w[23:18]), valid: 1'b1, last: 1'b0};
          r[1] = '{data: enc_sym(w[17:12]), valid: 1'b1, last: 1'b0};
          r[2] = '{data: PadChar, valid: 1'b1, last: 1'b0};
          r[3] = '{data: PadChar, valid: 1'b1, last: 1'b0};
          n    = 3'd4;
        end else if (end_of_stream_i && cnt_g_d >= 2'd2) begin
          w    = {bits_d[15:0], 8'h00};
          r[0] = '{data: enc_sym(w[23:18]), valid: 1'b1, last: 1'b0};
          r[1] = '{data: enc_sym(w[17:12]), valid: 1'b1, last: 1'b0};
          r[2] = '{data: enc_sym(w[11:6]),  valid: 1'b1, last: 1'b0};
          r[3] = '{data: PadChar, valid: 1'b1, last: 1'b0};
          n    = 3'd4;
        end
      end
    end else begin
      if (has_byte_i && !stop_q) begin
        if (!dv[6]) begin
          stop_d = 1'b1;
        end else if (cnt_g_q == 2'd3) begin
          w    = {bits_q, dv[5:0]};
          r[0] = '{data: w[23:16], valid: 1'b1, last: 1'b0};
          r[1] = '{data: w[15:8],  valid: 1'b1, last: 1'b0};
          r[2] = '{data: w[7:0],   valid: 1'b1, last: 1'b0};
          n       = 3'd3;
          bits_d  = 18'd0;
          cnt_g_d = 2'd0;
        end else begin
          bits_d  = {bits_q[11:0], dv[5:0]};
          cnt_g_d = 2'(cnt_g_q + 2'd1);
        end
      end
      if (end_of_stream_i && cnt_g_d == 2'd2) begin
        r[0] = '{data: bits_d[11:4], valid: 1'b1, last: 1'b0};
        n    = 3'd1;
      end else if (end_of_stream_i && cnt_g_d == 2'd3) begin
        r[0] = '{data: bits_d[17:10], valid: 1'b1, last: 1'b0};
        r[1] = '{data: bits_d[9:2],   valid: 1'b1, last: 1'b0};
        n    = 3'd2;
      end
    end

    if (end_of_stream_i) begin
      // Empty end still gives one result to carry the last flag.
      if (n == 3'd0) begin
        n = 3'd1;
      end
      r[2'(n - 3'd1)].last = 1'b1;
      bits_d  = 18'd0;
      cnt_g_d = 2'd0;
      stop_d  = 1'b0;
    end
  end

  // Result queue update: shift out the head, then append this request's results.
  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      q_d[i] = q_q[i];
    end
    if (pop) begin
      for (int i = 0; i < QDepth - 1; i++) begin
        q_d[i] = q_q[i + 1];
      end
    end
    base = 4'(qcnt_q - {3'd0, pop});
    if (acc) begin
      for (int i = 0; i < ResPerItem; i++) begin
        if (3'(i) < n) begin
          q_d[3'(base + 4'(i))] = r[i];
        end
      end
    end
    qcnt_d = 4'(base + ((acc) ? {1'b0, n} : 4'd0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      bits_q  <= 18'd0;
      cnt_g_q <= 2'd0;
      stop_q  <= 1'b0;
      qcnt_q  <= 4'd0;
    end else begin
      qcnt_q <= qcnt_d;
      if (cfg_we_i) begin
        // A mode write aborts any stream in progress.
        mode_q  <= cfg_wdata_i;
        bits_q  <= 18'd0;
        cnt_g_q <= 2'd0;
        stop_q  <= 1'b0;
      end else if (acc) begin
        bits_q  <= bits_d;
        cnt_g_q <= cnt_g_d;
        stop_q  <= stop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

// Testbench for base64_codec. A behavioral predictor tracks the codec state
// (held group, group count, stop flag and mode) and turns every accepted request
// into the results it must cause. Those results are queued in order. A receive
// process compares each result the block hands over with the oldest queued one.
module tb;
  import b64_pkg::*;

  // The block takes a request and queues its results at once; a request that
  // causes no result is settled well within the SettleCycles wait.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxIdle      = 16;
  localparam int unsigned RandomItems  = 85;
  localparam int unsigned ReportLimit  = 10;

  // Symbol alphabet by 6-bit value, first character in the top byte.
  localparam logic [8*64-1:0] SymTable =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+/";

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       cfg_we_i        = 1'b0;
  logic       cfg_wdata_i     = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i     = 8'h00;
  logic       has_byte_i      = 1'b0;
  logic       end_of_stream_i = 1'b0;
  logic       res_valid_o;
  logic       res_ready_i     = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_valid_o;
  logic       out_last_o;

  base64_codec i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .has_byte_i     (has_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .out_byte_o     (out_byte_o),
    .out_valid_o    (out_valid_o),
    .out_last_o     (out_last_o)
  );

  always #6 clk_i = ~clk_i;

  // Predicted codec state. It mirrors the block right after reset.
  logic        mode_dec = 1'b0;
  logic [17:0] grp_bits = '0;
  logic [1:0]  grp_cnt  = '0;
  logic        halted   = 1'b0;

  // Results still owed by the block, oldest first.
  res_t expected_out[$];

  // When set, neither side inserts idle cycles.
  bit          calm       = 1'b0;
  int unsigned bad_cnt    = 0;
  int unsigned useful_cnt = 0;
  int unsigned rx_hold    = 0;
  res_t        want;

  function automatic logic [7:0] sym_char(input logic [5:0] v);
    return SymTable[8*(63 - int'(v)) +: 8];
  endfunction

  // Returns the 6-bit value of an alphabet character, or -1 for anything else
  // (the pad character included).
  function automatic int char_value(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (sym_char(6'(i)) == c) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic res_t byte_out(input logic [7:0] d, input logic v);
    return {d, v, 1'b0};
  endfunction

  // Advances the predicted state by one accepted request and queues the results.
  function automatic void codec_step(input logic [7:0] b, input logic has,
                                     input logic eos);
    logic [23:0] w;
    int          v;
    int unsigned n;
    res_t        r;
    n = 0;
    if (!mode_dec) begin
      if (has) begin
        if (grp_cnt >= 2) begin
          w = {grp_bits[15:0], b};
          expected_out.push_back(byte_out(sym_char(w[23:18]), 1'b1));
          expected_out.push_back(byte_out(sym_char(w[17:12]), 1'b1));
          expected_out.push_back(byte_out(sym_char(w[11:6]), 1'b1));
          expected_out.push_back(byte_out(sym_char(w[5:0]), 1'b1));
          n += 4;
          grp_bits = '0;
          grp_cnt  = '0;
        end else begin
          grp_bits = {grp_bits[9:0], b};
          grp_cnt++;
        end
      end
      if (eos) begin
        if (grp_cnt == 1) begin
          w = {grp_bits[7:0], 16'h0000};
          expected_out.push_back(byte_out(sym_char(w[23:18]), 1'b1));
          expected_out.push_back(byte_out(sym_char(w[17:12]), 1'b1));
          expected_out.push_back(byte_out(PadChar, 1'b1));
          expected_out.push_back(byte_out(PadChar, 1'b1));
          n += 4;
        end else if (grp_cnt >= 2) begin
          w = {grp_bits[15:0], 8'h00};
          expected_out.push_back(byte_out(sym_char(w[23:18]), 1'b1));
          expected_out.push_back(byte_out(sym_char(w[17:12]), 1'b1));
          expected_out.push_back(byte_out(sym_char(w[11:6]), 1'b1));
          expected_out.push_back(byte_out(PadChar, 1'b1));
          n += 4;
        end
      end
    end else begin
      if (has && !halted) begin
        v = char_value(b);
        if (v < 0) begin
          halted = 1'b1;
        end else if (grp_cnt == 3) begin
          w = {grp_bits, 6'(v)};
          expected_out.push_back(byte_out(w[23:16], 1'b1));
          expected_out.push_back(byte_out(w[15:8], 1'b1));
          expected_out.push_back(byte_out(w[7:0], 1'b1));
          n += 3;
          grp_bits = '0;
          grp_cnt  = '0;
        end else begin
          grp_bits = {grp_bits[11:0], 6'(v)};
          grp_cnt++;
        end
      end
      if (eos) begin
        if (grp_cnt == 2) begin
          w = {grp_bits[11:0], 12'h000};
          expected_out.push_back(byte_out(w[23:16], 1'b1));
          n += 1;
        end else if (grp_cnt == 3) begin
          w = {grp_bits, 6'h00};
          expected_out.push_back(byte_out(w[23:16], 1'b1));
          expected_out.push_back(byte_out(w[15:8], 1'b1));
          n += 2;
        end
      end
    end
    if (eos) begin
      // A stream end with nothing pending still yields one empty result.
      if (n == 0) begin
        expected_out.push_back(byte_out(8'h00, 1'b0));
      end
      r = expected_out.pop_back();
      r.last = 1'b1;
      expected_out.push_back(r);
      grp_bits = '0;
      grp_cnt  = '0;
      halted   = 1'b0;
    end
  endfunction

  // A byte that suits the current mode. In decode mode it is mostly an alphabet
  // character, sometimes the pad character or an arbitrary byte.
  function automatic logic [7:0] pick_byte();
    if (!mode_dec) begin
      return 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 19) == 0) begin
      return $urandom_range(0, 1) ? PadChar : 8'($urandom_range(0, 255));
    end
    return sym_char(6'($urandom_range(0, 63)));
  endfunction

  // Sends one request. Valid is left high after acceptance so that a request
  // with no gap follows without a dip; wait_idle lowers it.
  task automatic send_req(input logic [7:0] data, input logic has, input logic eos);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= data;
    has_byte_i      <= has;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    // Count only requests that the block does not just drop.
    if (eos || (has && !(mode_dec && halted))) begin
      useful_cnt++;
    end
    codec_step(data, has, eos);
  endtask

  task automatic send_text(input string s, input bit eos_last);
    for (int i = 0; i < s.len(); i++) begin
      send_req(s[i], 1'b1, eos_last && (i == s.len() - 1));
    end
  endtask

  // Holds the sender until every owed result has arrived, then lets the block
  // settle any request that produced nothing.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes decode_mode; the block must be idle. Any held group is dropped.
  task automatic set_mode(input logic m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_dec = m;
    grp_bits = '0;
    grp_cnt  = '0;
    halted   = 1'b0;
  endtask

  // Encode: a one-byte group with double padding, a two-byte group with single
  // padding, a full group followed by a request without byte and an empty end.
  task automatic test_encode_groups();
    wait_idle();
    set_mode(1'b0);
    send_req(8'h00, 1'b1, 1'b1);
    send_req(8'hff, 1'b1, 1'b0);
    send_req(8'hfe, 1'b1, 1'b1);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'hff, 1'b1, 1'b0);
    send_req(8'h80, 1'b1, 1'b0);
    send_req(8'h5a, 1'b0, 1'b0);
    send_req(8'ha5, 1'b0, 1'b1);
  endtask

  // Decode: a full group ended by its own last character, a short group stopped
  // by a zero byte on the end request, a three-symbol tail, a lone symbol that
  // gives an empty end, and a pad stop with characters after it.
  task automatic test_decode_groups();
    wait_idle();
    set_mode(1'b1);
    send_text("aZ09", 1'b1);
    send_text("+/", 1'b0);
    send_req(8'h00, 1'b1, 1'b1);
    send_text("Ab/", 1'b1);
    send_text("q", 1'b1);
    send_text("ab=", 1'b0);
    send_req(8'hff, 1'b1, 1'b0);
    send_text("c", 1'b1);
  endtask

  // A mode write in the middle of a stream throws the held group away, also
  // when the written value does not change the mode.
  task automatic test_mode_abort();
    wait_idle();
    set_mode(1'b1);
    send_text("Zz", 1'b0);
    wait_idle();
    set_mode(1'b0);
    send_req(8'h41, 1'b1, 1'b1);
    send_req(8'h12, 1'b1, 1'b0);
    wait_idle();
    set_mode(1'b0);
    send_req(8'h00, 1'b0, 1'b1);
  endtask

  // Random streams in phases of alternating mode. Some phases run without idle
  // cycles, some streams are left open for the next mode write to abort, and the
  // sender sometimes waits for the output side to drain mid-stream.
  task automatic test_random_streams();
    int unsigned phase;
    int unsigned len;
    phase      = 0;
    useful_cnt = 0;
    while (useful_cnt < RandomItems) begin
      wait_idle();
      calm = ($urandom_range(0, 3) == 0);
      set_mode(phase[0]);
      repeat ($urandom_range(1, 4)) begin
        len = $urandom_range(0, 12);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            send_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          end else begin
            send_req(pick_byte(), 1'b1, 1'b0);
          end
          if ($urandom_range(0, 15) == 0) begin
            wait_idle();
          end
        end
        send_req(pick_byte(), 1'($urandom_range(0, 1)), 1'b1);
      end
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) send_req(pick_byte(), 1'b1, 1'b0);
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  // Result side: draws a stall after every accepted result and checks each one
  // against the oldest owed result.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ready_i <= 1'b0;
      rx_hold = 0;
    end else if (res_valid_o && res_ready_i) begin
      if (expected_out.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= ReportLimit) begin
          $display("unexpected result: byte %02h valid %0b last %0b",
                   out_byte_o, out_valid_o, out_last_o);
        end
      end else begin
        want = expected_out.pop_front();
        if (out_byte_o !== want.data || out_valid_o !== want.valid ||
            out_last_o !== want.last) begin
          bad_cnt++;
          if (bad_cnt <= ReportLimit) begin
            $display("result mismatch: byte %02h/%02h valid %0b/%0b last %0b/%0b",
                     out_byte_o, want.data, out_valid_o, want.valid,
                     out_last_o, want.last);
          end
        end
      end
      rx_hold = calm ? 0 : $urandom_range(0, MaxIdle);
      res_ready_i <= (rx_hold == 0);
    end else if (rx_hold > 0) begin
      rx_hold--;
      res_ready_i <= (rx_hold == 0);
    end else begin
      res_ready_i <= 1'b1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_encode_groups();
    test_decode_groups();
    test_mode_abort();
    test_random_streams();
    wait_idle();
    if (bad_cnt == 0 && expected_out.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Far beyond the slowest correct run: a few hundred requests, each with its
  // longest gap and four results that each wait out the longest stall.
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
